@@ hw/rtl/dcs_pkg.sv @@
// Shared types and constants of the control-sequence stream parser.
// Used by every module under hw/rtl except dcs_fifo; depends on nothing.
package dcs_pkg;

  // request types of an input item
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_EOI  = 2'd2;

  // result kinds
  localparam logic [1:0] RK_BYTE    = 2'd0;
  localparam logic [1:0] RK_END_OK  = 2'd1;
  localparam logic [1:0] RK_END_BAD = 2'd2;
  localparam logic [1:0] RK_TIMEOUT = 2'd3;

  // characters of interest
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] seq_id;
  } result_t;

  // item class decided by the front end
  typedef enum logic [3:0] {
    CLS_ESC,
    CLS_P,
    CLS_PLUS,
    CLS_SEMI,
    CLS_BEL,
    CLS_DIGIT,
    CLS_OTHER,
    CLS_TICK,
    CLS_EOI,
    CLS_NONE
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ID,
    PH_PAYLOAD
  } phase_e;

endpackage

@@ hw/rtl/dcs_fifo.sv @@
// Small first-word-fall-through queue of registers.
// Generic payload width; no package dependency.
module dcs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/dcs_front.sv @@
// Front end: classifies each accepted input item for the back end.
// Depends on dcs_pkg.
module dcs_front (
  input  logic               push_i,
  input  dcs_pkg::in_item_t  in_item_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output dcs_pkg::cmd_t      cmd_o
);

  assign q_push_o = push_i && !q_full_i;

  // request type and byte class
  always_comb begin
    cmd_o.data = in_item_i.data_byte;
    case (in_item_i.req_type)
      dcs_pkg::REQ_BYTE: begin
        case (in_item_i.data_byte) inside
          dcs_pkg::CH_ESC:                     cmd_o.cls = dcs_pkg::CLS_ESC;
          dcs_pkg::CH_P:                       cmd_o.cls = dcs_pkg::CLS_P;
          dcs_pkg::CH_PLUS:                    cmd_o.cls = dcs_pkg::CLS_PLUS;
          dcs_pkg::CH_SEMI:                    cmd_o.cls = dcs_pkg::CLS_SEMI;
          dcs_pkg::CH_BEL:                     cmd_o.cls = dcs_pkg::CLS_BEL;
          [dcs_pkg::CH_ZERO:dcs_pkg::CH_NINE]: cmd_o.cls = dcs_pkg::CLS_DIGIT;
          default:                             cmd_o.cls = dcs_pkg::CLS_OTHER;
        endcase
      end
      dcs_pkg::REQ_TICK: cmd_o.cls = dcs_pkg::CLS_TICK;
      dcs_pkg::REQ_EOI:  cmd_o.cls = dcs_pkg::CLS_EOI;
      default:           cmd_o.cls = dcs_pkg::CLS_NONE;
    endcase
  end

endmodule

@@ hw/rtl/dcs_back.sv @@
// Back end: parser state machine, id accumulator and hunt timeout.
// Depends on dcs_pkg; fed from the command queue, feeds the result queue.
module dcs_back #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  dcs_pkg::cmd_t     cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output dcs_pkg::result_t  res_o
);

  dcs_pkg::phase_e    phase_q, phase_d;
  logic [1:0]         match_q, match_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic               valid_q, valid_d;
  logic [31:0]        idle_q, idle_d;
  logic [31:0]        timeout_q;
  logic               fire;
  logic [ID_BITS+3:0] id_mac;
  logic [ID_BITS-1:0] id_sat;
  logic               emit;
  logic               to_hunt;

  assign fire      = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = fire;

  // id * 10 + digit, saturating at all ones
  assign id_mac = {1'b0, id_q, 3'b000} + {3'b000, id_q, 1'b0}
                + {ID_BITS'(0), cmd_i.data[3:0]};
  assign id_sat = (id_mac[ID_BITS+3:ID_BITS] != '0) ? '1 : id_mac[ID_BITS-1:0];

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      case (phase_q)
        dcs_pkg::PH_HUNT: begin
          if (cmd_i.cls == dcs_pkg::CLS_PLUS && match_q == 2'd2) begin
            phase_d = dcs_pkg::PH_ID;
          end
        end
        dcs_pkg::PH_ID: begin
          case (cmd_i.cls)
            dcs_pkg::CLS_EOI, dcs_pkg::CLS_BEL:    phase_d = dcs_pkg::PH_HUNT;
            dcs_pkg::CLS_TICK, dcs_pkg::CLS_NONE,
            dcs_pkg::CLS_DIGIT:                    phase_d = dcs_pkg::PH_ID;
            default:                               phase_d = dcs_pkg::PH_PAYLOAD;
          endcase
        end
        dcs_pkg::PH_PAYLOAD: begin
          if (cmd_i.cls == dcs_pkg::CLS_EOI || cmd_i.cls == dcs_pkg::CLS_BEL) begin
            phase_d = dcs_pkg::PH_HUNT;
          end
        end
        default: phase_d = dcs_pkg::PH_HUNT;
      endcase
    end
  end

  // datapath and results
  always_comb begin
    match_d           = match_q;
    id_d              = id_q;
    valid_d           = valid_q;
    idle_d            = idle_q;
    emit              = 1'b0;
    to_hunt           = 1'b0;
    res_o.result_kind = dcs_pkg::RK_BYTE;
    res_o.payload_byte = '0;
    res_o.seq_id      = '0;
    if (fire) begin
      case (phase_q)
        dcs_pkg::PH_HUNT: begin
          case (cmd_i.cls)
            dcs_pkg::CLS_TICK: begin
              if (idle_q != '0) begin
                idle_d = idle_q - 32'd1;
              end else begin
                emit              = 1'b1;
                to_hunt           = 1'b1;
                res_o.result_kind = dcs_pkg::RK_TIMEOUT;
              end
            end
            dcs_pkg::CLS_EOI: begin
              emit              = 1'b1;
              to_hunt           = 1'b1;
              res_o.result_kind = dcs_pkg::RK_TIMEOUT;
            end
            dcs_pkg::CLS_NONE: ;
            dcs_pkg::CLS_ESC: match_d = 2'd1;
            dcs_pkg::CLS_P:   match_d = (match_q == 2'd1) ? 2'd2 : 2'd0;
            dcs_pkg::CLS_PLUS: begin
              match_d = 2'd0;
              if (match_q == 2'd2) begin
                id_d    = '0;
                valid_d = 1'b0;
              end
            end
            default: match_d = 2'd0;
          endcase
        end
        dcs_pkg::PH_ID: begin
          case (cmd_i.cls)
            dcs_pkg::CLS_EOI: begin
              emit              = 1'b1;
              to_hunt           = 1'b1;
              res_o.result_kind = dcs_pkg::RK_END_BAD;
            end
            dcs_pkg::CLS_TICK, dcs_pkg::CLS_NONE: ;
            dcs_pkg::CLS_SEMI: valid_d = 1'b1;
            dcs_pkg::CLS_BEL: begin
              emit              = 1'b1;
              to_hunt           = 1'b1;
              res_o.result_kind = dcs_pkg::RK_END_OK;
              res_o.seq_id      = 16'(id_q);
            end
            dcs_pkg::CLS_DIGIT: id_d = id_sat;
            default: valid_d = 1'b0;
          endcase
        end
        dcs_pkg::PH_PAYLOAD: begin
          case (cmd_i.cls)
            dcs_pkg::CLS_EOI: begin
              emit              = 1'b1;
              to_hunt           = 1'b1;
              res_o.result_kind = dcs_pkg::RK_END_BAD;
            end
            dcs_pkg::CLS_TICK, dcs_pkg::CLS_NONE: ;
            dcs_pkg::CLS_BEL: begin
              emit    = 1'b1;
              to_hunt = 1'b1;
              if (valid_q) begin
                res_o.result_kind = dcs_pkg::RK_END_OK;
                res_o.seq_id      = 16'(id_q);
              end else begin
                res_o.result_kind = dcs_pkg::RK_END_BAD;
              end
            end
            default: begin
              emit               = 1'b1;
              res_o.result_kind  = dcs_pkg::RK_BYTE;
              res_o.payload_byte = cmd_i.data;
            end
          endcase
        end
        default: to_hunt = 1'b1;
      endcase
      // any end or timeout clears the parser and reloads the idle count
      if (to_hunt) begin
        match_d = 2'd0;
        id_d    = '0;
        valid_d = 1'b0;
        idle_d  = timeout_q;
      end
    end
    // a register write reloads the idle count too
    if (cfg_we_i) begin
      idle_d = cfg_wdata_i;
    end
  end

  assign res_push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dcs_pkg::PH_HUNT;
      match_q   <= 2'd0;
      id_q      <= '0;
      valid_q   <= 1'b0;
      idle_q    <= dcs_pkg::TIMEOUT_RESET;
      timeout_q <= dcs_pkg::TIMEOUT_RESET;
    end else begin
      phase_q <= phase_d;
      match_q <= match_d;
      id_q    <= id_d;
      valid_q <= valid_d;
      idle_q  <= idle_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ hw/rtl/dcs_sequence_parser.sv @@
// Top level of the control-sequence stream parser.
// Depends on dcs_pkg, dcs_front, dcs_fifo and dcs_back.
//
// Accepts one item (byte, idle tick or end of input) per clock cycle and
// sustains that rate indefinitely while results are popped; each item is
// processed by the back-end state machine, which sets the rate.
// A result is registered in the result queue, its item in the command queue.
// A two-entry command queue sits between the classifier and the state
// machine, and a two-entry result queue in front of the result ports, so
// input and output stall independently. No clearing pass is needed after
// reset. A configuration write also reloads the hunt idle count.
module dcs_sequence_parser #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  dcs_pkg::in_item_t in_item_i,
  input  logic              pop,
  output logic              empty,
  output dcs_pkg::result_t  result_o
);

  localparam int unsigned CmdW = $bits(dcs_pkg::cmd_t);
  localparam int unsigned ResW = $bits(dcs_pkg::result_t);

  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  dcs_pkg::cmd_t    cmd_in, cmd_out;
  logic             res_push, res_full;
  dcs_pkg::result_t res_in;

  // classifier
  dcs_front u_front (
    .push_i    (push),
    .in_item_i (in_item_i),
    .q_full_i  (cmd_full),
    .q_push_o  (cmd_push),
    .cmd_o     (cmd_in)
  );

  assign full = cmd_full;

  // command queue
  dcs_fifo #(
    .WIDTH (CmdW),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // parser state machine
  dcs_back #(
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue
  dcs_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

@@ tb/dcs_seq_checker.sv @@
// Checker for the control-sequence stream parser: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on dcs_pkg only.
module dcs_seq_checker #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              push_i,
  input  logic              full_i,
  input  dcs_pkg::in_item_t in_item_i,
  input  logic              pop_i,
  input  logic              empty_i,
  input  dcs_pkg::result_t  result_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam longint unsigned ID_MAX = (64'd1 << ID_BITS) - 64'd1;

  // parser state as the block should hold it
  dcs_pkg::phase_e cur_phase;
  logic [1:0]      mark_hits;
  longint unsigned seq_num;
  logic            num_ok;
  logic [31:0]     ticks_left;
  logic [31:0]     tick_limit;

  // results still owed by the block, oldest first
  dcs_pkg::result_t owed_results[$];

  task automatic restart_hunt();
    cur_phase  = dcs_pkg::PH_HUNT;
    mark_hits  = 2'd0;
    seq_num    = 0;
    num_ok     = 1'b0;
    ticks_left = tick_limit;
  endtask

  task automatic close_sequence(input logic ok, output dcs_pkg::result_t res);
    res             = '0;
    res.result_kind = ok ? dcs_pkg::RK_END_OK : dcs_pkg::RK_END_BAD;
    res.seq_id      = ok ? seq_num[15:0] : 16'd0;
    restart_hunt();
  endtask

  // one item through the parser; at most one result
  task automatic parse_item(input dcs_pkg::in_item_t it, output bit produced,
                            output dcs_pkg::result_t res);
    longint unsigned grown;
    produced = 1'b0;
    res      = '0;
    if (cur_phase == dcs_pkg::PH_HUNT) begin
      case (it.req_type)
        dcs_pkg::REQ_TICK: begin
          if (ticks_left != 32'd0) begin
            ticks_left--;
          end else begin
            restart_hunt();
            produced        = 1'b1;
            res.result_kind = dcs_pkg::RK_TIMEOUT;
          end
        end
        dcs_pkg::REQ_EOI: begin
          restart_hunt();
          produced        = 1'b1;
          res.result_kind = dcs_pkg::RK_TIMEOUT;
        end
        dcs_pkg::REQ_BYTE: begin
          // ESC always restarts the mark, even halfway through one
          if (it.data_byte == dcs_pkg::CH_ESC) begin
            mark_hits = 2'd1;
          end else if (it.data_byte == dcs_pkg::CH_P && mark_hits == 2'd1) begin
            mark_hits = 2'd2;
          end else if (it.data_byte == dcs_pkg::CH_PLUS && mark_hits == 2'd2) begin
            cur_phase = dcs_pkg::PH_ID;
            mark_hits = 2'd0;
            seq_num   = 0;
            num_ok    = 1'b0;
          end else begin
            mark_hits = 2'd0;
          end
        end
        default: ;
      endcase
    end else if (it.req_type == dcs_pkg::REQ_EOI) begin
      close_sequence(1'b0, res);
      produced = 1'b1;
    end else if (it.req_type == dcs_pkg::REQ_BYTE) begin
      if (cur_phase == dcs_pkg::PH_ID) begin
        if (it.data_byte == dcs_pkg::CH_SEMI) begin
          num_ok    = 1'b1;
          cur_phase = dcs_pkg::PH_PAYLOAD;
        end else if (it.data_byte == dcs_pkg::CH_BEL) begin
          close_sequence(1'b1, res);
          produced = 1'b1;
        end else if (it.data_byte >= dcs_pkg::CH_ZERO && it.data_byte <= dcs_pkg::CH_NINE) begin
          grown   = seq_num * 10 + longint'(it.data_byte - dcs_pkg::CH_ZERO);
          seq_num = (grown > ID_MAX) ? ID_MAX : grown;
        end else begin
          // stray byte: id spoilt, byte dropped, payload follows
          num_ok    = 1'b0;
          cur_phase = dcs_pkg::PH_PAYLOAD;
        end
      end else if (it.data_byte == dcs_pkg::CH_BEL) begin
        close_sequence(num_ok, res);
        produced = 1'b1;
      end else begin
        produced         = 1'b1;
        res.result_kind  = dcs_pkg::RK_BYTE;
        res.payload_byte = it.data_byte;
      end
    end
  endtask

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    fail_count_o++;
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  // register writes, result transactions, then item transactions
  always @(posedge clk_i or negedge rst_ni) begin
    dcs_pkg::result_t want;
    dcs_pkg::result_t fresh;
    bit               produced;
    if (!rst_ni) begin
      tick_limit = dcs_pkg::TIMEOUT_RESET;
      restart_hunt();
      owed_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        tick_limit = cfg_wdata_i;
        ticks_left = cfg_wdata_i;
      end

      if (pop_i && !empty_i) begin
        if (owed_results.size() == 0) begin
          fail_count_o++;
          $error("result transaction with none owed: kind %0d byte 0x%0h id %0d",
                 result_i.result_kind, result_i.payload_byte, result_i.seq_id);
        end else begin
          want = owed_results.pop_front();
          if (result_i.result_kind !== want.result_kind)
            flag_field("result_kind", want.result_kind, result_i.result_kind);
          if (result_i.payload_byte !== want.payload_byte)
            flag_field("payload_byte", want.payload_byte, result_i.payload_byte);
          if (result_i.seq_id !== want.seq_id)
            flag_field("seq_id", want.seq_id, result_i.seq_id);
        end
      end

      if (push_i && !full_i) begin
        parse_item(in_item_i, produced, fresh);
        if (produced)
          owed_results.insert(owed_results.size(), fresh);
      end

      pending_o = owed_results.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the control-sequence stream parser testbench: clock, reset, stimulus
// and verdict. Depends on dcs_pkg, dcs_sequence_parser and dcs_seq_checker.
module tb_top;
  import dcs_pkg::*;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned ITEM_TARGET  = 1200;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned QUIET_TAIL   = 200;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  in_item_t    in_item   = '0;
  result_t     result;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on     = 1'b1;

  always #4 clk_i = ~clk_i;

  dcs_sequence_parser #(
    .ID_BITS(16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .pop        (pop),
    .empty      (empty),
    .result_o   (result)
  );

  dcs_seq_checker #(
    .ID_BITS(16)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .push_i      (push),
    .full_i      (full),
    .in_item_i   (in_item),
    .pop_i       (pop),
    .empty_i     (empty),
    .result_i    (result),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // one item transaction, with an occasional sender gap ahead of it
  task automatic send(input logic [1:0] req, input logic [7:0] data);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    push              = 1'b1;
    in_item.req_type  = req;
    in_item.data_byte = data;
    do @(posedge clk_i); while (full);
    if (req != REQ_UNUSED)
      items_sent++;
  endtask

  // hold off the sender until every owed result has come out
  task automatic settle();
    @(negedge clk_i);
    push = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    settle();
    // items with no result may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // start mark (now and then broken), id, terminator, payload, end
  task automatic send_sequence();
    int unsigned digits;
    int unsigned body_len;
    int unsigned pick;
    logic [7:0]  stray;
    pick = $urandom_range(0, 19);
    send(REQ_BYTE, CH_ESC);
    if (pick == 0) send(REQ_BYTE, CH_ESC);
    if (pick == 1) send(REQ_BYTE, 8'($urandom()));
    send(REQ_BYTE, CH_P);
    if (pick == 2) send(REQ_BYTE, CH_P);
    send(REQ_BYTE, CH_PLUS);

    digits = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
    repeat (digits) send(REQ_BYTE, 8'(CH_ZERO + $urandom_range(0, 9)));

    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      send(REQ_BYTE, CH_SEMI);
    end else if (pick < 14) begin
      send(REQ_BYTE, CH_BEL);
      return;
    end else if (pick < 17) begin
      do stray = 8'($urandom());
      while ((stray >= CH_ZERO && stray <= CH_NINE) || stray == CH_SEMI || stray == CH_BEL);
      send(REQ_BYTE, stray);
    end else begin
      send(REQ_EOI, 8'($urandom()));
      return;
    end

    body_len = $urandom_range(0, 12);
    repeat (body_len) begin
      pick = $urandom_range(0, 15);
      if (pick == 0)      send(REQ_TICK, 8'($urandom()));
      else if (pick == 1) send(REQ_UNUSED, 8'($urandom()));
      else                send(REQ_BYTE, 8'($urandom()));
    end
    if ($urandom_range(0, 4) == 0) send(REQ_EOI, 8'($urandom()));
    else                           send(REQ_BYTE, CH_BEL);
  endtask

  // line noise: ticks, stray bytes, end of input, unused requests
  task automatic send_noise();
    int unsigned pick;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)       send(REQ_TICK, 8'($urandom()));
      else if (pick < 8)  send(REQ_BYTE, 8'($urandom()));
      else if (pick == 8) send(REQ_EOI, 8'($urandom()));
      else                send(REQ_UNUSED, 8'($urandom()));
    end
  endtask

  // result side: pop with random stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        if (gaps_on && $urandom_range(0, 9) == 0)
          stall_left = $urandom_range(1, 18);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_idx;
    int unsigned phase_end;
    logic [31:0] limit_val;
    phase_idx = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: end of input while hunting
    send(REQ_EOI, 8'h00);
    // ESC restarting a mark, saturating id, payload with ignored items, good end
    send(REQ_BYTE, CH_ESC);
    send(REQ_BYTE, CH_ESC);
    send(REQ_BYTE, CH_P);
    send(REQ_BYTE, CH_PLUS);
    repeat (5) send(REQ_BYTE, CH_NINE);
    send(REQ_BYTE, CH_SEMI);
    send(REQ_BYTE, 8'hFF);
    send(REQ_TICK, 8'h00);
    send(REQ_UNUSED, 8'hFF);
    send(REQ_BYTE, CH_BEL);
    // id closed by BEL straight away
    send(REQ_BYTE, CH_ESC);
    send(REQ_BYTE, CH_P);
    send(REQ_BYTE, CH_PLUS);
    send(REQ_BYTE, CH_ZERO);
    send(REQ_BYTE, CH_BEL);
    // stray id byte, then end of input inside the sequence
    send(REQ_BYTE, CH_ESC);
    send(REQ_BYTE, CH_P);
    send(REQ_BYTE, CH_PLUS);
    send(REQ_BYTE, 8'h78);
    send(REQ_EOI, 8'h00);
    // hunt timeout on the third idle tick
    write_timeout(32'd2);
    repeat (3) send(REQ_TICK, 8'h00);

    // random phases, each under its own timeout setting
    while (items_sent < ITEM_TARGET) begin
      case (phase_idx % 6)
        0:       limit_val = 32'd0;
        1:       limit_val = 32'hFFFF_FFFF;
        2:       limit_val = $urandom_range(1, 8);
        3:       limit_val = TIMEOUT_RESET;
        4:       limit_val = $urandom();
        default: limit_val = $urandom_range(0, 3);
      endcase
      write_timeout(limit_val);
      gaps_on   = (items_sent + QUIET_TAIL < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 4) != 0) send_sequence();
        else                           send_noise();
      end
      phase_idx++;
    end

    gaps_on = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
